>>> sv/rash_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rash_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TOL_BITS   = 16;
    localparam int NUM_BITS   = COORD_BITS + FRAC_BITS;
    localparam int T_BITS     = 64;
    localparam int Q_BITS     = (NUM_BITS > 63) ? NUM_BITS : 63;
    localparam int LANES      = 4;
    // input register, one stage per quotient bit, six stages of post processing
    localparam int LATENCY    = NUM_BITS + 7;

    // lane order of the four slab dividers
    localparam int LANE_X_MIN = 0;
    localparam int LANE_X_MAX = 1;
    localparam int LANE_Y_MIN = 2;
    localparam int LANE_Y_MAX = 3;

    localparam logic signed [T_BITS-1:0] T_SAT = T_BITS'(64'sd1 <<< 62);
    localparam logic [Q_BITS-1:0] Q_SAT = Q_BITS'(1) << 62;
    localparam logic signed [T_BITS-1:0] T_LIMIT =
        (T_BITS'(64'sd1) <<< (COORD_BITS - 1)) - T_BITS'(64'sd1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] dir_x;
        logic signed [COORD_BITS-1:0] dir_y;
        logic signed [COORD_BITS-1:0] box_min_x;
        logic signed [COORD_BITS-1:0] box_min_y;
        logic signed [COORD_BITS-1:0] box_max_x;
        logic signed [COORD_BITS-1:0] box_max_y;
    } in_item_t;

    typedef struct packed {
        logic                         hit;
        logic [COORD_BITS-2:0]        hit_distance;
        logic signed [COORD_BITS-1:0] hit_point_x;
        logic signed [COORD_BITS-1:0] hit_point_y;
        logic signed [COORD_BITS-1:0] normal_x;
        logic signed [COORD_BITS-1:0] normal_y;
    } out_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] rem;
        logic [NUM_BITS-1:0]   nq;
    } div_lane_t;

    typedef struct packed {
        logic                         valid;
        logic signed [COORD_BITS-1:0] ox;
        logic signed [COORD_BITS-1:0] oy;
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
        logic [COORD_BITS-1:0]        dmag_x;
        logic [COORD_BITS-1:0]        dmag_y;
        logic                         neg_x;
        logic                         neg_y;
        logic                         ok;
        logic [LANES-1:0]             qsign;
    } side_t;

endpackage

`default_nettype wire

>>> sv/ray_aabb_slab_hit.sv
`timescale 1ns / 1ps
`default_nettype none

// 2d ray versus axis-aligned box, slab method, signed fixed point. one item is
// accepted in every cycle (busy stays low) and its result appears on result with
// done high for one cycle. the slab divider is four restoring dividers, one
// quotient bit per stage, followed by six stages of compare, multiply and
// saturate. results cannot be held off, the receiver must take every done
// pulse. compare_tolerance is written through cfg_write_en and cfg_write_data;
// the user must write it only while no item is in flight, the block itself
// does not enforce this.
module ray_aabb_slab_hit (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  rash_pkg::in_item_t   in_item,
    input  wire                  cfg_write_en,
    input  wire [15:0]           cfg_write_data,
    output logic                 done,
    output rash_pkg::out_item_t  result
);

    localparam int C  = rash_pkg::COORD_BITS;
    localparam int F  = rash_pkg::FRAC_BITS;
    localparam int NB = rash_pkg::NUM_BITS;
    localparam int TB = rash_pkg::T_BITS;
    localparam int L  = rash_pkg::LANES;

    logic [rash_pkg::TOL_BITS-1:0] tol_reg;

    // tolerance register, reset value one lsb
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= rash_pkg::TOL_BITS'(1);
        end
        else if (cfg_write_en)
        begin
            tol_reg <= cfg_write_data;
        end
    end

    // the pipeline never stalls
    assign busy = 1'b0;

    // ---------------------------------------------------------------------
    // stage 0: plane distances, direction magnitudes, negligible-axis tests
    // ---------------------------------------------------------------------
    logic signed [C+1:0] tol_c2;
    logic [C-1:0]        tol_c;
    logic signed [C:0]   diff [L];
    logic [C-1:0]        diff_mag [L];
    logic signed [C:0]   dx_e, dy_e;
    logic [C-1:0]        dmag_x, dmag_y;
    logic                neg_x, neg_y;
    logic                out_x, out_y;
    rash_pkg::side_t     side_in;

    always_comb
    begin
        tol_c  = C'(tol_reg);
        tol_c2 = $signed({2'b00, tol_c});
        diff[rash_pkg::LANE_X_MIN] = (C+1)'(in_item.box_min_x) - (C+1)'(in_item.origin_x);
        diff[rash_pkg::LANE_X_MAX] = (C+1)'(in_item.box_max_x) - (C+1)'(in_item.origin_x);
        diff[rash_pkg::LANE_Y_MIN] = (C+1)'(in_item.box_min_y) - (C+1)'(in_item.origin_y);
        diff[rash_pkg::LANE_Y_MAX] = (C+1)'(in_item.box_max_y) - (C+1)'(in_item.origin_y);
        for (int i = 0; i < L; i++)
        begin
            diff_mag[i] = diff[i][C] ? C'(-diff[i]) : diff[i][C-1:0];
        end
        dx_e   = (C+1)'(in_item.dir_x);
        dy_e   = (C+1)'(in_item.dir_y);
        dmag_x = dx_e[C] ? C'(-dx_e) : dx_e[C-1:0];
        dmag_y = dy_e[C] ? C'(-dy_e) : dy_e[C-1:0];
        neg_x  = (dmag_x <= tol_c);
        neg_y  = (dmag_y <= tol_c);
        // origin below min or above max, with tolerance
        out_x  = ((C+2)'(in_item.origin_x) + tol_c2 < (C+2)'(in_item.box_min_x))
              || ((C+2)'(in_item.origin_x) > (C+2)'(in_item.box_max_x) + tol_c2);
        out_y  = ((C+2)'(in_item.origin_y) + tol_c2 < (C+2)'(in_item.box_min_y))
              || ((C+2)'(in_item.origin_y) > (C+2)'(in_item.box_max_y) + tol_c2);

        side_in.valid  = start;
        side_in.ox     = in_item.origin_x;
        side_in.oy     = in_item.origin_y;
        side_in.dx     = in_item.dir_x;
        side_in.dy     = in_item.dir_y;
        side_in.dmag_x = dmag_x;
        side_in.dmag_y = dmag_y;
        side_in.neg_x  = neg_x;
        side_in.neg_y  = neg_y;
        side_in.ok     = !(neg_x && out_x) && !(neg_y && out_y);
        side_in.qsign[rash_pkg::LANE_X_MIN] = diff[rash_pkg::LANE_X_MIN][C] ^ in_item.dir_x[C-1];
        side_in.qsign[rash_pkg::LANE_X_MAX] = diff[rash_pkg::LANE_X_MAX][C] ^ in_item.dir_x[C-1];
        side_in.qsign[rash_pkg::LANE_Y_MIN] = diff[rash_pkg::LANE_Y_MIN][C] ^ in_item.dir_y[C-1];
        side_in.qsign[rash_pkg::LANE_Y_MAX] = diff[rash_pkg::LANE_Y_MAX][C] ^ in_item.dir_y[C-1];
    end

    // ---------------------------------------------------------------------
    // divider pipeline: stage k+1 develops one more quotient bit
    // ---------------------------------------------------------------------
    rash_pkg::div_lane_t lane_reg [NB+1][L];
    rash_pkg::side_t     side_reg [NB+1];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < L; i++)
        begin
            lane_reg[0][i].rem <= '0;
            lane_reg[0][i].nq  <= {diff_mag[i], {F{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg[0] <= '0;
        end
        else
        begin
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_div
        for (genvar l = 0; l < L; l++)
        begin : g_lane
            logic [C:0]          trial;
            logic [C:0]          sub;
            logic [C-1:0]        divisor;
            logic                qbit;
            rash_pkg::div_lane_t lane_next;

            always_comb
            begin
                divisor = (l < 2) ? side_reg[k].dmag_x : side_reg[k].dmag_y;
                trial   = {lane_reg[k][l].rem, lane_reg[k][l].nq[NB-1]};
                sub     = trial - {1'b0, divisor};
                qbit    = !sub[C];
                lane_next.rem = qbit ? sub[C-1:0] : trial[C-1:0];
                lane_next.nq  = {lane_reg[k][l].nq[NB-2:0], qbit};
            end

            always_ff @(posedge clk)
            begin
                lane_reg[k+1][l] <= lane_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k+1] <= '0;
            end
            else
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // ---------------------------------------------------------------------
    // stage a: signed, capped slab distances
    // ---------------------------------------------------------------------
    logic signed [TB-1:0] ta_next [L];
    logic signed [TB-1:0] ta_reg  [L];
    rash_pkg::side_t      side_a_reg;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            logic [rash_pkg::Q_BITS-1:0] qe;
            logic [TB-1:0]               qm;
            qe = rash_pkg::Q_BITS'(lane_reg[NB][i].nq);
            if (qe > rash_pkg::Q_SAT)
            begin
                qe = rash_pkg::Q_SAT;
            end
            qm = TB'(qe[62:0]);
            ta_next[i] = side_reg[NB].qsign[i] ? -$signed(qm) : $signed(qm);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < L; i++)
        begin
            ta_reg[i] <= ta_next[i];
        end
    end

    // ---------------------------------------------------------------------
    // stage b: slab entry and exit per axis
    // ---------------------------------------------------------------------
    logic signed [TB-1:0] nx_reg, fx_reg, ny_reg, fy_reg;
    rash_pkg::side_t      side_b_reg;

    always_ff @(posedge clk)
    begin
        if (side_a_reg.neg_x)
        begin
            nx_reg <= -rash_pkg::T_SAT;
            fx_reg <= rash_pkg::T_SAT;
        end
        else if (ta_reg[rash_pkg::LANE_X_MIN] < ta_reg[rash_pkg::LANE_X_MAX])
        begin
            nx_reg <= ta_reg[rash_pkg::LANE_X_MIN];
            fx_reg <= ta_reg[rash_pkg::LANE_X_MAX];
        end
        else
        begin
            nx_reg <= ta_reg[rash_pkg::LANE_X_MAX];
            fx_reg <= ta_reg[rash_pkg::LANE_X_MIN];
        end
        if (side_a_reg.neg_y)
        begin
            ny_reg <= -rash_pkg::T_SAT;
            fy_reg <= rash_pkg::T_SAT;
        end
        else if (ta_reg[rash_pkg::LANE_Y_MIN] < ta_reg[rash_pkg::LANE_Y_MAX])
        begin
            ny_reg <= ta_reg[rash_pkg::LANE_Y_MIN];
            fy_reg <= ta_reg[rash_pkg::LANE_Y_MAX];
        end
        else
        begin
            ny_reg <= ta_reg[rash_pkg::LANE_Y_MAX];
            fy_reg <= ta_reg[rash_pkg::LANE_Y_MIN];
        end
    end

    // ---------------------------------------------------------------------
    // stage c: tmin is the later entry, tmax the earlier exit
    // ---------------------------------------------------------------------
    logic signed [TB-1:0] tmin_reg, tmax_reg;
    rash_pkg::side_t      side_c_reg;

    always_ff @(posedge clk)
    begin
        tmin_reg <= (nx_reg > ny_reg) ? nx_reg : ny_reg;
        tmax_reg <= (fx_reg < fy_reg) ? fx_reg : fy_reg;
    end

    // ---------------------------------------------------------------------
    // stage d: hit decision and clamped distance
    // ---------------------------------------------------------------------
    logic signed [TB-1:0] tol_t;
    logic signed [TB-1:0] tsel;
    logic                 hit_next;
    logic [C-2:0]         t_next;
    logic                 hit_reg;
    logic [C-2:0]         t_reg;
    rash_pkg::side_t      side_d_reg;

    always_comb
    begin
        tol_t    = $signed(TB'(tol_reg));
        hit_next = side_c_reg.ok
                && !(tmax_reg + tol_t < 0)
                && !(tmin_reg > tmax_reg + tol_t);
        // origin inside the box: take the exit
        tsel     = (tmin_reg + tol_t < 0) ? tmax_reg : tmin_reg;
        if (tsel < 0)
        begin
            t_next = '0;
        end
        else if (tsel > rash_pkg::T_LIMIT)
        begin
            t_next = rash_pkg::T_LIMIT[C-2:0];
        end
        else
        begin
            t_next = tsel[C-2:0];
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        t_reg   <= t_next;
    end

    // ---------------------------------------------------------------------
    // stage e: direction magnitude times distance
    // ---------------------------------------------------------------------
    logic [2*C-2:0]  prod_x_reg, prod_y_reg;
    logic            hit_e_reg;
    logic [C-2:0]    t_e_reg;
    rash_pkg::side_t side_e_reg;

    always_ff @(posedge clk)
    begin
        prod_x_reg <= (2*C-1)'(side_d_reg.dmag_x) * (2*C-1)'(t_reg);
        prod_y_reg <= (2*C-1)'(side_d_reg.dmag_y) * (2*C-1)'(t_reg);
        hit_e_reg  <= hit_reg;
        t_e_reg    <= t_reg;
    end

    // sideband valid chain through the post-divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
            side_b_reg <= '0;
            side_c_reg <= '0;
            side_d_reg <= '0;
            side_e_reg <= '0;
        end
        else
        begin
            side_a_reg <= side_reg[NB];
            side_b_reg <= side_a_reg;
            side_c_reg <= side_b_reg;
            side_d_reg <= side_c_reg;
            side_e_reg <= side_d_reg;
        end
    end

    // ---------------------------------------------------------------------
    // stage f: hit point, normal, saturation, output register
    // ---------------------------------------------------------------------
    function automatic logic signed [C-1:0] point_sat(
        input logic signed [C-1:0] o,
        input logic signed [C-1:0] d,
        input logic [2*C-2:0]      p
    );
        logic [2*C-2:0]      ps;
        logic [C:0]          m;
        logic signed [C+1:0] s;
        ps = p >> F;
        if (ps > (2*C-1)'({1'b1, {C{1'b0}}}))
        begin
            m = {1'b1, {C{1'b0}}};
        end
        else
        begin
            m = ps[C:0];
        end
        if (d[C-1])
        begin
            s = (C+2)'(o) - $signed({1'b0, m});
        end
        else
        begin
            s = (C+2)'(o) + $signed({1'b0, m});
        end
        if (s > $signed((C+2)'({1'b0, {(C-1){1'b1}}})))
        begin
            point_sat = {1'b0, {(C-1){1'b1}}};
        end
        else if (s < $signed((C+2)'({{3{1'b1}}, {(C-1){1'b0}}})))
        begin
            point_sat = {1'b1, {(C-1){1'b0}}};
        end
        else
        begin
            point_sat = s[C-1:0];
        end
    endfunction

    // negation, most negative value maps to the largest positive
    function automatic logic signed [C-1:0] neg_sat(input logic signed [C-1:0] d);
        if (d == {1'b1, {(C-1){1'b0}}})
        begin
            neg_sat = {1'b0, {(C-1){1'b1}}};
        end
        else
        begin
            neg_sat = -d;
        end
    endfunction

    rash_pkg::out_item_t result_next;
    rash_pkg::out_item_t result_reg;
    logic                done_reg;

    always_comb
    begin
        result_next = '0;
        if (hit_e_reg)
        begin
            result_next.hit          = 1'b1;
            result_next.hit_distance = t_e_reg;
            result_next.hit_point_x  = point_sat(side_e_reg.ox, side_e_reg.dx, prod_x_reg);
            result_next.hit_point_y  = point_sat(side_e_reg.oy, side_e_reg.dy, prod_y_reg);
            result_next.normal_x     = neg_sat(side_e_reg.dx);
            result_next.normal_y     = neg_sat(side_e_reg.dy);
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= side_e_reg.valid;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> sv/rash_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rash_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 start,
    input wire                 busy,
    input wire                 done,
    input rash_pkg::out_item_t result
);

    // every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(rash_pkg::LATENCY) done)
        else $error("item did not complete at the pipeline latency");

    // no result without an item accepted the latency before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, rash_pkg::LATENCY))
        else $error("result without a matching item");

    // a miss carries all zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result == '0))
        else $error("miss with nonzero fields");

    // the pipeline never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind ray_aabb_slab_hit rash_checker u_rash_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
